FILE: design/io_latency_mlp_admission_macros.svh
// Assertion macros used by the admission predictor back end.
`ifndef IO_LATENCY_MLP_ADMISSION_MACROS_SVH
`define IO_LATENCY_MLP_ADMISSION_MACROS_SVH
`ifndef ASSERT_OFF
`define IOL_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
`define IOL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define IOL_ASSERT(label, expr, msg)
`define IOL_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: design/iolm_pkg.sv
package iolm_pkg;

   localparam int NUM_DEVICES_DEF = 2;
   localparam int HIDDEN_SIZE_DEF = 256;
   localparam int PENDING_CAP_DEF = 999;
   localparam int LATENCY_CAP_DEF = 9999;
   localparam int FEATURE_COUNT   = 31;
   localparam int FEAT_W          = $clog2(FEATURE_COUNT);
   localparam int Q_DEPTH         = 2;
   localparam int Q_PW            = $clog2(Q_DEPTH);

   typedef enum logic [1:0] {
      OP_INFER  = 2'd0,
      OP_UPDATE = 2'd1,
      OP_WRITE  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      TBL_HW = 2'd0,
      TBL_OW = 2'd1,
      TBL_HB = 2'd2,
      TBL_OB = 2'd3
   } tbl_type;

   typedef enum logic [1:0] {
      KIND_INFER,
      KIND_UPDATE,
      KIND_WRITE
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_HMAC,
      ST_HDRAIN,
      ST_RELU,
      ST_OMUL,
      ST_ODRAIN,
      ST_FIN0,
      ST_FIN1,
      ST_FIN2,
      ST_RESP
   } state_type;

   typedef struct packed {
      kind_type     kind;
      logic         dev;
      logic [15:0]  size;
      logic [15:0]  lat;
      tbl_type      tbl;
      logic [12:0]  idx;
      logic [31:0]  val;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   // Decimal digit at position pos (0 = ones) of v < 10000, by reciprocal multiplies
   function automatic logic [3:0] dec_digit(logic [13:0] v, logic [1:0] pos);
      logic [31:0] q0;
      logic [31:0] q1;
      logic [31:0] q2;
      logic [31:0] q3;
      logic [31:0] lo;
      logic [31:0] hi;
      q0 = {18'd0, v};
      q1 = (q0 * 32'd52429) >> 19;
      q2 = (q0 * 32'd5243) >> 19;
      q3 = (q0 * 32'd8389) >> 23;
      unique case (pos)
         2'd0: begin lo = q0; hi = q1; end
         2'd1: begin lo = q1; hi = q2; end
         2'd2: begin lo = q2; hi = q3; end
         default: begin lo = q3; hi = 32'd0; end
      endcase
      return 4'(lo - hi * 32'd10);
   endfunction

endpackage

FILE: design/iolm_front.sv
module iolm_front import iolm_pkg::*; #(
   parameter int NUM_DEVICES = NUM_DEVICES_DEF,
   parameter int HIDDEN_SIZE = HIDDEN_SIZE_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [1:0]     req_operation,
   input  logic           req_device,
   input  logic [15:0]    req_io_size,
   input  logic [15:0]    req_latency,
   input  logic [1:0]     req_weight_table,
   input  logic [12:0]    req_weight_index,
   input  logic [31:0]    req_weight_value,
   output queue_head_type q_head,
   input  logic           q_pop
);

   item_type          cls_item;
   logic              cls_keep;
   logic              dev_ok;
   logic              idx_ok;
   logic              push;
   item_type          q_mem_ff [Q_DEPTH];
   logic [Q_PW-1:0]   wp_ff;
   logic [Q_PW:0]     cnt_ff;
   logic [Q_PW-1:0]   rp_ff;

   // Classify the beat: drop unused codes and out-of-range writes
   always_comb begin
      dev_ok = int'(req_device) < NUM_DEVICES;
      unique case (tbl_type'(req_weight_table))
         TBL_HW:  idx_ok = int'(req_weight_index) < HIDDEN_SIZE * FEATURE_COUNT;
         TBL_OW:  idx_ok = int'(req_weight_index) < HIDDEN_SIZE * 2;
         TBL_HB:  idx_ok = int'(req_weight_index) < HIDDEN_SIZE;
         default: idx_ok = int'(req_weight_index) < 2;
      endcase
      cls_item.dev  = req_device;
      cls_item.size = req_io_size;
      cls_item.lat  = req_latency;
      cls_item.tbl  = tbl_type'(req_weight_table);
      cls_item.idx  = req_weight_index;
      cls_item.val  = req_weight_value;
      cls_item.kind = KIND_WRITE;
      cls_keep      = 1'b0;
      unique case (req_operation)
         OP_INFER: begin
            cls_item.kind = KIND_INFER;
            cls_item.dev  = dev_ok ? req_device : 1'b0;
            cls_keep      = 1'b1;
         end
         OP_UPDATE: begin
            cls_item.kind = KIND_UPDATE;
            cls_keep      = 1'b1;
         end
         OP_WRITE: begin
            cls_keep = dev_ok && idx_ok;
         end
         default: cls_keep = 1'b0;
      endcase
   end

   assign req_ready    = cnt_ff != (Q_PW+1)'(Q_DEPTH);
   assign push         = req_valid && req_ready && cls_keep;
   assign q_head.valid = cnt_ff != '0;
   assign q_head.item  = q_mem_ff[rp_ff];

   // Hold queued items
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wp_ff] <= cls_item;
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (q_pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (Q_PW+1)'(push) - (Q_PW+1)'(q_pop);
      end
   end

endmodule

FILE: design/iolm_back.sv
`include "io_latency_mlp_admission_macros.svh"
module iolm_back import iolm_pkg::*; #(
   parameter int NUM_DEVICES = NUM_DEVICES_DEF,
   parameter int HIDDEN_SIZE = HIDDEN_SIZE_DEF,
   parameter int PENDING_CAP = PENDING_CAP_DEF,
   parameter int LATENCY_CAP = LATENCY_CAP_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  queue_head_type      q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_redirect,
   output logic signed [63:0]  rsp_score_keep,
   output logic signed [63:0]  rsp_score_redirect
);

   localparam int HW_PER_DEV = HIDDEN_SIZE * FEATURE_COUNT;
   localparam int HW_DEPTH   = NUM_DEVICES * HW_PER_DEV;
   localparam int HB_DEPTH   = NUM_DEVICES * HIDDEN_SIZE;
   localparam int OW_DEPTH   = NUM_DEVICES * HIDDEN_SIZE * 2;
   localparam int OB_DEPTH   = NUM_DEVICES * 2;
   localparam int HW_AW      = $clog2(HW_DEPTH);
   localparam int HB_AW      = $clog2(HB_DEPTH);
   localparam int OW_AW      = $clog2(OW_DEPTH);
   localparam int OB_AW      = $clog2(OB_DEPTH);
   localparam int J_W        = $clog2(HIDDEN_SIZE);

   state_type           state_ff, state_in;
   item_type            item_ff, item_in;
   logic [FEAT_W-1:0]   i_ff, i_in;
   logic [J_W-1:0]      j_ff, j_in;
   logic [1:0]          k_ff, k_in;
   logic [HW_AW-1:0]    hw_addr_ff, hw_addr_in;
   logic [3:0]          feat_ff [FEATURE_COUNT];
   logic [3:0]          feat_in [FEATURE_COUNT];
   logic                feat_load;
   logic [63:0]         acc_ff, acc_in;
   logic [63:0]         act_ff, act_in;
   logic [63:0]         s0_ff, s0_in;
   logic [63:0]         s1_ff, s1_in;
   logic                v1_ff, v1_in;
   logic [FEAT_W-1:0]   i1_ff;
   logic                v2_ff;
   logic signed [36:0]  prod_ff;
   logic                mv_ff, mv_in;
   logic [1:0]          mk_ff;
   logic [63:0]         mult_ff;
   logic [9:0]          pend_ff, pend_in;
   logic [9:0]          pend_hist_ff [4];
   logic [13:0]         lat_hist_ff [4];
   logic                hist_shift;
   logic [13:0]         lat_cap;
   logic [16:0]         pend_sum;
   logic [16:0]         pend_diff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_load;
   logic                redirect;

   // memories and their ports
   logic [31:0]         hw_mem [HW_DEPTH];
   logic [31:0]         hb_mem [HB_DEPTH];
   logic [31:0]         ow_mem [OW_DEPTH];
   logic [31:0]         ob_mem [OB_DEPTH];
   logic [31:0]         hw_rd_ff, hb_rd_ff, ow_rd_ff, ob_rd_ff, ow0_ff;
   logic                hw_we, hb_we, ow_we, ob_we;
   logic                hw_re, hb_re, ow_re, ob_re;
   logic [HW_AW-1:0]    hw_waddr;
   logic [HB_AW-1:0]    hb_waddr, hb_raddr;
   logic [OW_AW-1:0]    ow_waddr, ow_raddr;
   logic [OB_AW-1:0]    ob_waddr, ob_raddr;
   logic [32:0]         mul_a;
   logic [31:0]         mul_b;
   logic [63:0]         bias_sum;
   logic [63:0]         mult_term;
   logic [13:0]         dv;

   // Split the state into decimal digit features
   always_comb begin
      for (int h = 0; h < 5; h++) begin
         dv = (h == 4) ? {4'd0, pend_ff} : {4'd0, pend_hist_ff[3-h]};
         for (int d = 0; d < 3; d++) begin
            feat_in[h*3+d] = dec_digit(dv, 2'(2-d));
         end
      end
      for (int h = 0; h < 4; h++) begin
         for (int d = 0; d < 4; d++) begin
            feat_in[15+h*4+d] = dec_digit(lat_hist_ff[3-h], 2'(3-d));
         end
      end
   end

   // Write and read addresses
   assign hw_waddr = HW_AW'(int'(item_ff.dev) * HW_PER_DEV + int'(item_ff.idx));
   assign hb_waddr = HB_AW'(int'(item_ff.dev) * HIDDEN_SIZE + int'(item_ff.idx));
   assign ow_waddr = OW_AW'(int'(item_ff.dev) * HIDDEN_SIZE * 2 + int'(item_ff.idx));
   assign ob_waddr = OB_AW'(int'(item_ff.dev) * 2 + int'(item_ff.idx));
   assign hb_raddr = HB_AW'(int'(item_ff.dev) * HIDDEN_SIZE + int'(j_ff));
   assign ow_raddr = OW_AW'(int'(item_ff.dev) * HIDDEN_SIZE * 2
                            + (i_ff[0] ? HIDDEN_SIZE : 0) + int'(j_ff));
   assign ob_raddr = OB_AW'(int'(item_ff.dev) * 2 + ((state_ff == ST_FIN1) ? 1 : 0));

   // Completion arithmetic
   assign lat_cap   = (int'(item_ff.lat) > LATENCY_CAP) ? 14'(LATENCY_CAP) : item_ff.lat[13:0];
   assign pend_sum  = {7'd0, pend_ff} + {1'b0, item_ff.size};
   assign pend_diff = {7'd0, pend_ff} - {1'b0, item_ff.size};
   assign redirect  = $signed(s0_ff) < $signed(s1_ff);
   assign bias_sum  = acc_ff + {{32{hb_rd_ff[31]}}, hb_rd_ff};
   assign mul_a     = k_ff[0] ? {1'b0, act_ff[63:32]} : {1'b0, act_ff[31:0]};
   assign mul_b     = k_ff[1] ? ow_rd_ff : ow0_ff;
   assign mult_term = mk_ff[0] ? {mult_ff[31:0], 32'd0} : mult_ff;

   // Sequence the item: next state, counters and strobes
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      hw_addr_in   = hw_addr_ff;
      act_in       = act_ff;
      pend_in      = pend_ff;
      acc_in       = v2_ff ? acc_ff + {{27{prod_ff[36]}}, prod_ff} : acc_ff;
      s0_in        = (mv_ff && !mk_ff[1]) ? s0_ff + mult_term : s0_ff;
      s1_in        = (mv_ff && mk_ff[1]) ? s1_ff + mult_term : s1_ff;
      v1_in        = 1'b0;
      mv_in        = 1'b0;
      q_pop        = 1'b0;
      feat_load    = 1'b0;
      hist_shift   = 1'b0;
      hw_we        = 1'b0;
      hb_we        = 1'b0;
      ow_we        = 1'b0;
      ob_we        = 1'b0;
      hw_re        = 1'b0;
      hb_re        = 1'b0;
      ow_re        = 1'b0;
      ob_re        = 1'b0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               q_pop    = 1'b1;
               item_in  = q_head.item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (item_ff.kind)
               KIND_WRITE: begin
                  unique case (item_ff.tbl)
                     TBL_HW:  hw_we = 1'b1;
                     TBL_OW:  ow_we = 1'b1;
                     TBL_HB:  hb_we = 1'b1;
                     default: ob_we = 1'b1;
                  endcase
               end
               KIND_UPDATE: begin
                  hist_shift = 1'b1;
                  pend_in    = pend_diff[16] ? 10'd0 : pend_diff[9:0];
               end
               default: begin
                  feat_load  = 1'b1;
                  i_in       = '0;
                  j_in       = '0;
                  acc_in     = '0;
                  s0_in      = '0;
                  s1_in      = '0;
                  hw_addr_in = HW_AW'(int'(item_ff.dev) * HW_PER_DEV);
                  state_in   = ST_HMAC;
               end
            endcase
         end
         ST_HMAC: begin
            hw_re      = 1'b1;
            hb_re      = i_ff == '0;
            ow_re      = i_ff <= FEAT_W'(1);
            v1_in      = 1'b1;
            hw_addr_in = hw_addr_ff + 1'b1;
            if (i_ff == FEAT_W'(FEATURE_COUNT - 1)) begin
               i_in     = '0;
               state_in = ST_HDRAIN;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_HDRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = ST_RELU;
            end
         end
         ST_RELU: begin
            act_in   = bias_sum[63] ? 64'd0 : bias_sum;
            k_in     = '0;
            state_in = ST_OMUL;
         end
         ST_OMUL: begin
            mv_in = 1'b1;
            k_in  = k_ff + 1'b1;
            if (k_ff == 2'd3) begin
               state_in = ST_ODRAIN;
            end
         end
         ST_ODRAIN: begin
            if (!mv_ff) begin
               if (j_ff == J_W'(HIDDEN_SIZE - 1)) begin
                  state_in = ST_FIN0;
               end else begin
                  j_in     = j_ff + 1'b1;
                  acc_in   = '0;
                  state_in = ST_HMAC;
               end
            end
         end
         ST_FIN0: begin
            ob_re    = 1'b1;
            state_in = ST_FIN1;
         end
         ST_FIN1: begin
            ob_re    = 1'b1;
            s0_in    = s0_ff + {{32{ob_rd_ff[31]}}, ob_rd_ff};
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            s1_in    = s1_ff + {{32{ob_rd_ff[31]}}, ob_rd_ff};
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (!redirect) begin
                  pend_in = (int'(pend_sum) > PENDING_CAP) ? 10'(PENDING_CAP) : pend_sum[9:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         mv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= '0;
         for (int n = 0; n < 4; n++) begin
            pend_hist_ff[n] <= '0;
            lat_hist_ff[n]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         v1_ff        <= v1_in;
         v2_ff        <= v1_ff;
         mv_ff        <= mv_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         if (hist_shift) begin
            pend_hist_ff[0] <= pend_ff;
            lat_hist_ff[0]  <= lat_cap;
            for (int n = 1; n < 4; n++) begin
               pend_hist_ff[n] <= pend_hist_ff[n-1];
               lat_hist_ff[n]  <= lat_hist_ff[n-1];
            end
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      hw_addr_ff <= hw_addr_in;
      acc_ff     <= acc_in;
      act_ff     <= act_in;
      s0_ff      <= s0_in;
      s1_ff      <= s1_in;
      i1_ff      <= i_ff;
      mk_ff      <= k_ff;
      prod_ff    <= $signed({1'b0, feat_ff[i1_ff]}) * $signed(hw_rd_ff);
      mult_ff    <= 64'($signed(mul_a) * $signed(mul_b));
      if (state_ff == ST_HMAC && i_ff == FEAT_W'(1)) begin
         ow0_ff <= ow_rd_ff;
      end
      if (feat_load) begin
         feat_ff <= feat_in;
      end
      if (rsp_load) begin
         rsp_redirect       <= redirect;
         rsp_score_keep     <= s0_ff;
         rsp_score_redirect <= s1_ff;
      end
   end

   // Weight memories
   always_ff @(posedge clock) begin
      if (hw_we) begin
         hw_mem[hw_waddr] <= item_ff.val;
      end
      if (hw_re) begin
         hw_rd_ff <= hw_mem[hw_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (hb_we) begin
         hb_mem[hb_waddr] <= item_ff.val;
      end
      if (hb_re) begin
         hb_rd_ff <= hb_mem[hb_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ow_we) begin
         ow_mem[ow_waddr] <= item_ff.val;
      end
      if (ow_re) begin
         ow_rd_ff <= ow_mem[ow_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ob_we) begin
         ob_mem[ob_waddr] <= item_ff.val;
      end
      if (ob_re) begin
         ob_rd_ff <= ob_mem[ob_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `IOL_ASSERT(a_pend_cap, pend_ff <= 10'(PENDING_CAP), "pending count above cap")
   `IOL_ASSERT(a_lat_cap, lat_hist_ff[0] <= 14'(LATENCY_CAP), "latency history above cap")
   `IOL_ASSERT_NEXT(a_relu_nonneg, state_ff == ST_RELU, act_ff[63] == 1'b0, "negative activation")
   `IOL_ASSERT(a_pipe_idle, (state_ff == ST_IDLE) |-> (!v1_ff && !v2_ff && !mv_ff), "pipe busy in idle")

endmodule

FILE: design/io_latency_mlp_admission.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    operation, device, io_size, latency, weight_*
// rsp_      out        rsp_valid/rsp_ready    redirect, score_keep, score_redirect
//
// Write and completion beats are handled in the back end's EXEC state; op code 3 and
// out-of-range writes are dropped at the front. In its HMAC phase an infer beat's single
// weight memory read port feeds the hidden MAC one weight a cycle. Reset is synchronous;
// weight memories are not cleared.
// A two-beat queue takes beats while the back end works or waits on rsp_ready;
// req_ready drops while the queue is full.
module io_latency_mlp_admission import iolm_pkg::*; #(
   parameter int NUM_DEVICES = NUM_DEVICES_DEF,
   parameter int HIDDEN_SIZE = HIDDEN_SIZE_DEF,
   parameter int PENDING_CAP = PENDING_CAP_DEF,
   parameter int LATENCY_CAP = LATENCY_CAP_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_operation,
   input  logic                req_device,
   input  logic [15:0]         req_io_size,
   input  logic [15:0]         req_latency,
   input  logic [1:0]          req_weight_table,
   input  logic [12:0]         req_weight_index,
   input  logic signed [31:0]  req_weight_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_redirect,
   output logic signed [63:0]  rsp_score_keep,
   output logic signed [63:0]  rsp_score_redirect
);

   queue_head_type q_head;
   logic           q_pop;

   iolm_front #(
      .NUM_DEVICES(NUM_DEVICES),
      .HIDDEN_SIZE(HIDDEN_SIZE)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_device       (req_device),
      .req_io_size      (req_io_size),
      .req_latency      (req_latency),
      .req_weight_table (req_weight_table),
      .req_weight_index (req_weight_index),
      .req_weight_value (req_weight_value),
      .q_head           (q_head),
      .q_pop            (q_pop)
   );

   iolm_back #(
      .NUM_DEVICES(NUM_DEVICES),
      .HIDDEN_SIZE(HIDDEN_SIZE),
      .PENDING_CAP(PENDING_CAP),
      .LATENCY_CAP(LATENCY_CAP)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_redirect       (rsp_redirect),
      .rsp_score_keep     (rsp_score_keep),
      .rsp_score_redirect (rsp_score_redirect)
   );

endmodule

FILE: tb/io_latency_mlp_admission_tb.sv
`timescale 1ns / 100ps

module io_latency_mlp_admission_tb;
   import iolm_pkg::*;

   localparam int HID       = HIDDEN_SIZE_DEF;
   localparam int HW_DEPTH  = HID * FEATURE_COUNT;
   localparam int OW_DEPTH  = HID * 2;
   localparam int CYCLE_CAP = 8000000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      bit     redirect;
      longint keep_sum;
      longint redir_sum;
   } verdict_type;

   // Admission predictor: mirrors pending/latency history and weight sets
   class admission_scoreboard;
      int          pend_cnt;
      int          pend_hist[4];
      int          lat_hist[4];
      int          hw[2][HW_DEPTH];
      int          hb[2][HID];
      int          ow[2][OW_DEPTH];
      int          ob[2][2];
      verdict_type verdicts[$];
      int          errors;

      function void clear_history();
         pend_cnt = 0;
         foreach (pend_hist[k]) pend_hist[k] = 0;
         foreach (lat_hist[k]) lat_hist[k] = 0;
      endfunction

      function int outstanding();
         return verdicts.size();
      endfunction

      // Note one accepted request beat and queue its verdict, if any
      function void note_beat(logic [1:0] op, bit dev, bit [15:0] size, bit [15:0] lat,
                              logic [1:0] tbl, bit [12:0] idx, bit [31:0] val);
         longint      feat[FEATURE_COUNT];
         longint      acc;
         longint      s0;
         longint      s1;
         int          n;
         int          v;
         verdict_type vd;
         if (op == OP_INFER) begin
            n = 0;
            for (int h = 4; h >= 0; h--) begin
               v = (h == 0) ? pend_cnt : pend_hist[h-1];
               feat[n++] = (v / 100) % 10;
               feat[n++] = (v / 10) % 10;
               feat[n++] = v % 10;
            end
            for (int h = 3; h >= 0; h--) begin
               v = lat_hist[h];
               feat[n++] = (v / 1000) % 10;
               feat[n++] = (v / 100) % 10;
               feat[n++] = (v / 10) % 10;
               feat[n++] = v % 10;
            end
            s0 = 0;
            s1 = 0;
            for (int j = 0; j < HID; j++) begin
               acc = 0;
               for (int i = 0; i < FEATURE_COUNT; i++)
                  acc += feat[i] * longint'(hw[dev][j*FEATURE_COUNT+i]);
               acc += longint'(hb[dev][j]);
               if (acc < 0) acc = 0;
               s0 += acc * longint'(ow[dev][j]);
               s1 += acc * longint'(ow[dev][HID+j]);
            end
            s0 += longint'(ob[dev][0]);
            s1 += longint'(ob[dev][1]);
            vd.redirect  = s0 < s1;
            vd.keep_sum  = s0;
            vd.redir_sum = s1;
            verdicts.push_back(vd);
            if (!vd.redirect)
               pend_cnt = (pend_cnt + size > PENDING_CAP_DEF) ? PENDING_CAP_DEF
                                                             : pend_cnt + size;
         end else if (op == OP_UPDATE) begin
            for (int k = 3; k > 0; k--) begin
               pend_hist[k] = pend_hist[k-1];
               lat_hist[k]  = lat_hist[k-1];
            end
            pend_hist[0] = pend_cnt;
            pend_cnt     = (size >= pend_cnt) ? 0 : pend_cnt - size;
            lat_hist[0]  = (lat > LATENCY_CAP_DEF) ? LATENCY_CAP_DEF : lat;
         end else if (op == OP_WRITE) begin
            case (tbl)
               TBL_HW: if (idx < HW_DEPTH) hw[dev][idx] = val;
               TBL_OW: if (idx < OW_DEPTH) ow[dev][idx] = val;
               TBL_HB: if (idx < HID) hb[dev][idx] = val;
               default: if (idx < 2) ob[dev][idx] = val;
            endcase
         end
      endfunction

      // Compare one response beat with the oldest queued verdict
      function void check_beat(bit redirect, longint keep_sum, longint redir_sum);
         verdict_type vd;
         if (verdicts.size() == 0) begin
            $display("%0t: unexpected response redirect=%0d keep=%0d redir=%0d",
                     $time, redirect, keep_sum, redir_sum);
            errors++;
            return;
         end
         vd = verdicts.pop_front();
         if (redirect != vd.redirect) begin
            $display("%0t: redirect expected %0d actual %0d", $time, vd.redirect, redirect);
            errors++;
         end
         if (keep_sum != vd.keep_sum) begin
            $display("%0t: score_keep expected %0d actual %0d", $time, vd.keep_sum, keep_sum);
            errors++;
         end
         if (redir_sum != vd.redir_sum) begin
            $display("%0t: score_redirect expected %0d actual %0d",
                     $time, vd.redir_sum, redir_sum);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_operation = OP_INFER;
   logic               req_device = 1'b0;
   logic [15:0]        req_io_size = '0;
   logic [15:0]        req_latency = '0;
   logic [1:0]         req_weight_table = TBL_HW;
   logic [12:0]        req_weight_index = '0;
   logic signed [31:0] req_weight_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_redirect;
   logic signed [63:0] rsp_score_keep;
   logic signed [63:0] rsp_score_redirect;

   admission_scoreboard sb = new();
   bit                  steady = 1'b0;
   int                  cycles = 0;

   io_latency_mlp_admission u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_device(req_device),
      .req_io_size(req_io_size), .req_latency(req_latency),
      .req_weight_table(req_weight_table), .req_weight_index(req_weight_index),
      .req_weight_value(req_weight_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_redirect(rsp_redirect), .rsp_score_keep(rsp_score_keep),
      .rsp_score_redirect(rsp_score_redirect)
   );

   always #4 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Randomly stall the response side outside the steady window and check accepted beats
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_beat(rsp_redirect, rsp_score_keep, rsp_score_redirect);
      rsp_ready <= steady || ($urandom_range(99) >= 37);
   end

   // Drive one request beat and hold it until accepted
   task automatic send(logic [1:0] op, bit dev, bit [15:0] size, bit [15:0] lat,
                       logic [1:0] tbl, bit [12:0] idx, bit [31:0] val);
      while (!steady && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_device       <= dev;
      req_io_size      <= size;
      req_latency      <= lat;
      req_weight_table <= tbl;
      req_weight_index <= idx;
      req_weight_value <= val;
      do @(posedge clock); while (!req_ready);
      sb.note_beat(op, dev, size, lat, tbl, idx, val);
   endtask

   task automatic send_write(bit dev, logic [1:0] tbl, bit [12:0] idx, bit [31:0] val);
      send(OP_WRITE, dev, 16'($urandom), 16'($urandom), tbl, idx, val);
   endtask

   task automatic send_infer(bit dev, bit [15:0] size);
      send(OP_INFER, dev, size, 16'($urandom), 2'($urandom), 13'($urandom), $urandom);
   endtask

   task automatic send_update(bit [15:0] size, bit [15:0] lat);
      send(OP_UPDATE, 1'($urandom), size, lat, 2'($urandom), 13'($urandom), $urandom);
   endtask

   task automatic send_unused();
      send(OP_UNUSED, 1'($urandom), 16'($urandom), 16'($urandom), 2'($urandom),
           13'($urandom), $urandom);
   endtask

   // Drop valid and wait until every verdict has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic bit [31:0] pick_weight(bit narrow);
      if (narrow) return 32'($signed($urandom_range(2000)) - 1000);
      return $urandom;
   endfunction

   // Fill every weight of one device; narrow values keep sums from wrapping
   task automatic load_device(bit dev, bit narrow);
      for (int k = 0; k < HW_DEPTH; k++) send_write(dev, TBL_HW, 13'(k), pick_weight(narrow));
      for (int k = 0; k < OW_DEPTH; k++) send_write(dev, TBL_OW, 13'(k), pick_weight(narrow));
      for (int k = 0; k < HID; k++) send_write(dev, TBL_HB, 13'(k), pick_weight(narrow));
      for (int k = 0; k < 2; k++) send_write(dev, TBL_OB, 13'(k), pick_weight(narrow));
   endtask

   initial begin
      int          pick;
      logic [1:0]  tbl;
      bit [12:0]   lim;
      sb.clear_history();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Load both weight sets, then hit the dropped cases
      load_device(1'b0, 1'b0);
      load_device(1'b1, 1'b1);
      send_write(1'b0, TBL_HW, 13'(HW_DEPTH), $urandom);
      send_write(1'b1, TBL_HW, 13'h1FFF, $urandom);
      send_write(1'b0, TBL_OW, 13'(OW_DEPTH), $urandom);
      send_write(1'b1, TBL_HB, 13'(HID), $urandom);
      send_write(1'b0, TBL_OB, 13'd2, $urandom);
      send_unused();

      // Directed: size and latency extremes, both devices, bias extremes
      send_infer(1'b0, 16'd0);
      send_infer(1'b1, 16'hFFFF);
      send_update(16'd0, 16'hFFFF);
      send_update(16'd1, 16'd9999);
      send_update(16'hFFFF, 16'd10000);
      send_infer(1'b1, 16'd998);
      send_update(16'd0, 16'd0);
      send_infer(1'b0, 16'd1);
      send_write(1'b1, TBL_OB, 13'd0, 32'h7FFFFFFF);
      send_write(1'b1, TBL_OB, 13'd1, 32'h80000000);
      send_infer(1'b1, 16'd500);
      send_write(1'b1, TBL_OB, 13'd0, 32'h80000000);
      send_write(1'b1, TBL_OB, 13'd1, 32'h7FFFFFFF);
      send_infer(1'b1, 16'd500);
      send_write(1'b0, TBL_HB, 13'(HID - 1), 32'h80000000);
      send_write(1'b0, TBL_HW, 13'(HW_DEPTH - 1), 32'h7FFFFFFF);
      send_infer(1'b0, 16'd300);

      // Random mix of beats
      for (int n = 0; n < 100; n++) begin
         if (n == 50) drain();
         steady = (n >= 60 && n < 80);
         pick = $urandom_range(99);
         if (pick < 35)
            send_infer(1'($urandom), 16'((pick < 10) ? $urandom : $urandom_range(400)));
         else if (pick < 65)
            send_update(16'((pick < 45) ? $urandom : $urandom_range(400)),
                        16'((pick < 50) ? $urandom : $urandom_range(12000)));
         else if (pick < 95) begin
            tbl = 2'($urandom);
            lim = 13'((tbl == TBL_HW) ? HW_DEPTH : (tbl == TBL_OW) ? OW_DEPTH
                : (tbl == TBL_HB) ? HID : 2);
            if (pick < 85)
               send_write(1'($urandom), tbl, 13'($urandom_range(lim - 1)), $urandom);
            else
               send_write(1'($urandom), tbl, 13'($urandom_range(13'h1FFF, lim)), $urandom);
         end else
            send_unused();
      end
      steady = 1'b0;

      drain();
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
